>>> hdl/tdpt_pkg.sv
package tdpt_pkg;

  localparam int FIELD_W       = 32;
  localparam int WIDTH_DEF     = 32;
  localparam int FIRST_DIVISOR = 2;

endpackage

>>> hdl/tdpt_if.sv
interface tdpt_in_if import tdpt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface tdpt_out_if import tdpt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] tested_number;
  logic               is_prime;

  modport source (output valid, output tested_number, output is_prime, input ready);
  modport sink   (input valid, input tested_number, input is_prime, output ready);
endinterface

>>> hdl/tdpt_div.sv
module tdpt_div import tdpt_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CW = $clog2(WIDTH + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [WIDTH-1:0] quo_r;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] dvs_r;

  logic [WIDTH:0]   shifted;
  logic [WIDTH+1:0] diff;
  logic             borrow;
  logic [WIDTH-1:0] rem_nxt;

  // one quotient bit per cycle, restoring form
  always_comb begin
    shifted = {rem_r, quo_r[WIDTH-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_r};
    borrow  = diff[WIDTH+1];
    rem_nxt = borrow ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(WIDTH);
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[WIDTH-2:0], ~borrow};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

>>> hdl/trial_division_prime_test.sv
// Trial-division primality test. Each accepted item carries a number; the
// block answers with one item that echoes the number and sets is_prime when
// no divisor from 2 to number-1 divides it (0 and 1 report prime). Divisors
// are tried in turn from 2 on a bit-serial restoring divider that yields one
// quotient bit per clock; the search ends at the first divisor that divides
// or once the divisor passes the square root of the number. The number of
// trial divisions is 1 for numbers below 4 and for even numbers, and up to
// about sqrt(number) for a prime. One item is in work at a time; a new item
// is taken while the last result still waits in the output register.
module trial_division_prime_test import tdpt_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  tdpt_in_if.sink    in_ch,
  tdpt_out_if.source out_ch
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_HOLD} state_t;

  state_t             state_r;
  logic [WIDTH-1:0]   n_r;
  logic [WIDTH-1:0]   d_r;
  logic               prime_r;
  logic               out_valid_r;
  logic [FIELD_W-1:0] out_num_r;
  logic               out_prime_r;

  logic               in_accept;
  logic               trial_stop;
  logic               trial_hit;
  logic               div_start;
  logic               div_done;
  logic [WIDTH-1:0]   div_dividend;
  logic [WIDTH-1:0]   div_divisor;
  logic [WIDTH-1:0]   div_quo;
  logic [WIDTH-1:0]   div_rem;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;

  // stop once divisor exceeds number / divisor
  assign trial_stop   = (div_quo < d_r);
  assign trial_hit    = (div_rem == '0);
  assign div_start    = in_accept ||
                        ((state_r == S_DIV) && div_done && !trial_stop && !trial_hit);
  assign div_dividend = in_accept ? WIDTH'(in_ch.number) : n_r;
  assign div_divisor  = in_accept ? WIDTH'(FIRST_DIVISOR) : d_r + WIDTH'(1);

  tdpt_div #(.WIDTH(WIDTH)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != S_HOLD)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            n_r     <= WIDTH'(in_ch.number);
            d_r     <= WIDTH'(FIRST_DIVISOR);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (trial_stop) begin
              prime_r <= 1'b1;
              state_r <= S_HOLD;
            end else if (trial_hit) begin
              prime_r <= 1'b0;
              state_r <= S_HOLD;
            end else begin
              d_r <= d_r + WIDTH'(1);
            end
          end
        end
        S_HOLD: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_num_r   <= FIELD_W'(n_r);
            out_prime_r <= prime_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.tested_number = out_num_r;
  assign out_ch.is_prime      = out_prime_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside a search");

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (state_r == S_IDLE || div_done))
    else $error("divider restarted while busy");

  a_load_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_HOLD))
    else $error("result loaded without a finished search");

  a_divisor_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (d_r >= WIDTH'(FIRST_DIVISOR)))
    else $error("trial divisor below two");

endmodule

>>> test/trial_division_prime_test_tb.sv
`timescale 1ns / 100ps

module trial_division_prime_test_tb;
  import tdpt_pkg::*;

  localparam int IDLE_LIMIT   = 200000;
  localparam int TRIAL_BUDGET = 1000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 80;

  localparam logic [FIELD_W-1:0] CORNER_NUMBERS [20] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49, 32'd65521,
    32'd994009, 32'd1000003, 32'd1022117, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
    32'h8000_0000, 32'h7FFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000
  };

  typedef struct packed {
    logic [FIELD_W-1:0] tested_number;
    logic               is_prime;
  } prime_verdict_t;

  class prime_scoreboard;
    prime_verdict_t awaited[$];
    int             mismatches;

    function new();
      mismatches = 0;
    endfunction

    // counts trial divisions up to the square root, stops at the first factor
    function int divisor_search(logic [FIELD_W-1:0] n, output bit found);
      longint unsigned num;
      longint unsigned d;
      int              trials;
      num    = n;
      d      = FIRST_DIVISOR;
      trials = 0;
      found  = 1'b0;
      while (d <= num / d) begin
        trials++;
        if (num % d == 0) begin
          found = 1'b1;
          break;
        end
        d++;
      end
      return trials;
    endfunction

    function void note_number(logic [FIELD_W-1:0] n);
      prime_verdict_t v;
      bit             found;
      void'(divisor_search(n, found));
      v.tested_number = n;
      v.is_prime      = !found;
      awaited.push_back(v);
    endfunction

    function void check_result(logic [FIELD_W-1:0] tested_number, logic is_prime);
      prime_verdict_t v;
      if (awaited.size() == 0) begin
        $error("unexpected item: tested_number %0d is_prime %0b", tested_number, is_prime);
        mismatches++;
        return;
      end
      v = awaited.pop_front();
      if (tested_number !== v.tested_number) begin
        $error("tested_number: expected %0d, got %0d", v.tested_number, tested_number);
        mismatches++;
      end
      if (is_prime !== v.is_prime) begin
        $error("is_prime: expected %0b, got %0b (number %0d)", v.is_prime, is_prime,
               v.tested_number);
        mismatches++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;
  int   idle_cycles;

  prime_scoreboard sb = new();

  tdpt_in_if  in_if();
  tdpt_out_if out_if();

  trial_division_prime_test #(
    .WIDTH(WIDTH_DEF)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
  endfunction

  // numbers whose search stays short enough for the run length
  function automatic logic [FIELD_W-1:0] pick_number();
    logic [FIELD_W-1:0] n;
    bit                 found;
    int                 kind;
    int                 k;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: begin
        n = $urandom_range(0, 300);
      end
      6, 7: begin
        n = $urandom_range(1000, 200000);
      end
      8: begin
        k = $urandom_range(2, 500);
        n = k * k;
      end
      9: begin
        do n = 32'hFFFF_FFFF - $urandom_range(0, 4095);
        while (sb.divisor_search(n, found) > TRIAL_BUDGET);
      end
      default: begin
        do n = $urandom;
        while (sb.divisor_search(n, found) > TRIAL_BUDGET);
      end
    endcase
    return n;
  endfunction

  task automatic send_number(input logic [FIELD_W-1:0] n);
    int gap;
    gap = calm ? 0 : (($urandom_range(0, 2) == 0) ? 0 : gap_len());
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid  = 1'b1;
    in_if.number = n;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin : receiver
    int stall;
    stall        = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_if.ready = 1'b0;
        stall--;
      end else begin
        out_if.ready = 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) sb.check_result(out_if.tested_number, out_if.is_prime);
      if (in_if.valid && in_if.ready) sb.note_number(in_if.number);
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("trial_division_prime_test: mismatch");
    $finish;
  end

  initial begin
    int fails;
    rst_n        = 1'b0;
    calm         = 1'b0;
    in_if.valid  = 1'b0;
    in_if.number = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    foreach (CORNER_NUMBERS[i]) send_number(CORNER_NUMBERS[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 30 && i < 45);
      if (i == 60) begin
        @(negedge clk);
        in_if.valid = 1'b0;
        wait_drained();
      end
      send_number(pick_number());
    end

    @(negedge clk);
    in_if.valid = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    fails = sb.mismatches + sb.pending();
    if (fails == 0) begin
      $display("trial_division_prime_test: match");
    end else begin
      $display("trial_division_prime_test: mismatch");
    end
    $finish;
  end

endmodule
